// File: hdl/prl_pkg.sv
// shared types and constants for the pump ramp leg sequencer
// no dependencies; used by prl_leg_mem and pump_ramp_leg_sequencer_unit
package prl_pkg;

    // default table depth
    localparam int MAX_LEGS_DEF = 8;

    // beat widths on the two stream sides
    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // one stored leg
    typedef struct packed {
        logic [7:0]        start;
        logic signed [8:0] delta;
        logic [31:0]       timeout;
        logic              action;
        logic              trigger;
    } t_leg;

endpackage

// File: hdl/prl_leg_mem.sv
// leg table memory: one write port, one registered read port
// entries read as zero until written since reset; uses prl_pkg
module prl_leg_mem
    import prl_pkg::*;
#(
    parameter int MAX_LEGS = MAX_LEGS_DEF,
    localparam int LW = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [LW-1:0] i_wr_addr,
    input  t_leg          i_wr_data,
    input  logic          i_rd_en,
    input  logic [LW-1:0] i_rd_addr,
    output t_leg          o_rd_data
);

    t_leg                r_mem [MAX_LEGS];
    logic [MAX_LEGS-1:0] r_valid;
    t_leg                r_rd_data;
    logic                r_rd_valid;

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: hdl/prl_addsub.sv
// shared 64-bit adder / subtractor for the arithmetic steps
// no dependencies
module prl_addsub (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum,
    output logic        o_carry
);

    logic [64:0] sum;

    // subtract as a + ~b + 1; carry out set means no borrow
    assign sum     = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {64'b0, i_sub};
    assign o_sum   = sum[63:0];
    assign o_carry = sum[64];

endmodule

// File: hdl/pump_ramp_leg_sequencer_unit.sv
// top level of the pump ramp leg sequencer: streams, register port, step sequencer
// uses prl_pkg, prl_leg_mem, prl_addsub
// Write, restart and no-op requests and ticks with no leg to run skip the step sequence;
// a running ramp tick may pass memory read, leg decode, end time, remaining time, compare,
// elapsed time, multiply, 9 restoring divide steps on the shared adder, rounding, advance.
// Throughput: one item at a time; input ready only in idle with no result pending.
// Reset: synchronous active low; clears leg valid bits, state and output valid, leg count 1.
module pump_ramp_leg_sequencer_unit
    import prl_pkg::*;
#(
    parameter int MAX_LEGS = MAX_LEGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_us, trigger_hit, leg_index, leg_start_power, leg_end_power,
    // leg_timeout_us, leg_is_action, leg_uses_trigger, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pump_setting, pump_changed, routine_finished, action_strobe, active_leg, status
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int LW = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_READ = 11'b000_0000_0010,
        S_LEG  = 11'b000_0000_0100,
        S_END  = 11'b000_0000_1000,
        S_REM  = 11'b000_0001_0000,
        S_CMP  = 11'b000_0010_0000,
        S_EL   = 11'b000_0100_0000,
        S_MUL  = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_FIN  = 11'b010_0000_0000,
        S_ADV  = 11'b100_0000_0000
    } t_state;

    // input beat fields
    t_req        in_req;
    logic [63:0] in_now;
    logic        in_trig;
    logic [7:0]  in_idx;
    logic [7:0]  in_sp;
    logic [7:0]  in_ep;
    logic [31:0] in_to;
    logic        in_act;
    logic        in_ut;

    assign in_req  = t_req'(s_axis_tuser[1:0]);
    assign in_now  = s_axis_tdata[63:0];
    assign in_trig = s_axis_tdata[64];
    assign in_idx  = s_axis_tdata[72:65];
    assign in_sp   = s_axis_tdata[80:73];
    assign in_ep   = s_axis_tdata[88:81];
    assign in_to   = s_axis_tdata[120:89];
    assign in_act  = s_axis_tdata[121];
    assign in_ut   = s_axis_tdata[122];

    // control registers
    t_state      r_state, n_state;
    logic [3:0]  r_num_legs;
    logic [3:0]  r_cur, n_cur;
    logic        r_started, n_started;
    logic [63:0] r_end, n_end;
    logic [7:0]  r_pump, n_pump;
    logic        r_changed, n_changed;
    logic        r_done, n_done;
    logic        r_ovalid, n_ovalid;
    logic        r_out_pend, n_out_pend;

    // payload registers
    logic [63:0] r_now, n_now;
    logic        r_trig, n_trig;
    logic        r_strobe, n_strobe;
    logic        r_status, n_status;
    logic [63:0] r_rem, n_rem;
    logic        r_le, n_le;
    logic [31:0] r_el, n_el;
    logic [40:0] r_mag, n_mag;
    logic [39:0] r_dvs, n_dvs;
    logic [8:0]  r_q, n_q;
    logic [3:0]  r_k, n_k;
    logic [OUT_DATA_W-1:0] r_out, n_out;

    // shared adder hookup
    logic [63:0] alu_a, alu_b, alu_sum;
    logic        alu_sub, alu_carry;

    // leg table hookup
    logic          mem_wr_en, mem_rd_en;
    t_leg          mem_wr_data, ent;

    logic [3:0]  cnt;
    logic [8:0]  d_u, d_abs;
    logic [8:0]  qc;
    logic        ended;
    logic        accept;

    // leg count in use
    assign cnt = (int'(r_num_legs) < MAX_LEGS) ? r_num_legs : 4'(MAX_LEGS);

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'b0, r_num_legs} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_legs <= 4'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_num_legs <= pwdata[3:0];
        end
    end

    // stream handshakes
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_pend;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // leg write data
    always_comb begin
        mem_wr_data.start   = in_sp;
        mem_wr_data.action  = in_act;
        mem_wr_data.delta   = in_act ? 9'sd0 : $signed({1'b0, in_ep} - {1'b0, in_sp});
        mem_wr_data.timeout = in_act ? 32'd0 : in_to;
        mem_wr_data.trigger = in_act ? 1'b0 : in_ut;
    end

    prl_leg_mem #(
        .MAX_LEGS (MAX_LEGS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (LW'(in_idx)),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (LW'(r_cur)),
        .o_rd_data (ent)
    );

    prl_addsub u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // delta magnitude and rounded quotient
    assign d_u   = ent.delta;
    assign d_abs = d_u[8] ? (~d_u + 9'd1) : d_u;
    assign qc    = r_q + {8'b0, (d_u[8] && (r_mag != 41'd0))};
    assign ended = ent.action || r_le || (ent.trigger && r_trig);

    // step sequencer
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_started  = r_started;
        n_end      = r_end;
        n_pump     = r_pump;
        n_changed  = r_changed;
        n_done     = r_done;
        n_ovalid   = r_ovalid;
        n_out_pend = r_out_pend;
        n_now      = r_now;
        n_trig     = r_trig;
        n_strobe   = r_strobe;
        n_status   = r_status;
        n_rem      = r_rem;
        n_le       = r_le;
        n_el       = r_el;
        n_mag      = r_mag;
        n_dvs      = r_dvs;
        n_q        = r_q;
        n_k        = r_k;
        n_out      = r_out;
        alu_a      = r_now;
        alu_b      = 64'd0;
        alu_sub    = 1'b0;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;

        // result beat taken downstream
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // load the finished result into the output register
                if (r_out_pend && (!r_ovalid || m_axis_tready)) begin
                    n_ovalid   = 1'b1;
                    n_out_pend = 1'b0;
                    n_out      = {r_status, r_cur, r_strobe, r_done, r_changed, r_pump};
                end
                if (accept) begin
                    n_now      = in_now;
                    n_trig     = in_trig;
                    n_strobe   = 1'b0;
                    n_status   = 1'b0;
                    n_out_pend = 1'b1;
                    case (in_req)
                        REQ_TICK: begin
                            if (r_done) begin
                                n_pump = 8'd0;
                            end else if (r_cur >= cnt) begin
                                n_done = 1'b1;
                                n_pump = 8'd0;
                            end else begin
                                n_out_pend = 1'b0;
                                n_state    = S_READ;
                            end
                        end
                        REQ_WRITE: begin
                            if (in_idx >= {4'b0, cnt}) begin
                                n_status = 1'b1;
                            end else begin
                                mem_wr_en = 1'b1;
                                if (in_idx == {4'b0, r_cur}) begin
                                    n_started = 1'b0;
                                end
                            end
                        end
                        REQ_RESTART: begin
                            n_cur     = 4'd0;
                            n_started = 1'b0;
                            n_pump    = 8'd0;
                            n_changed = 1'b0;
                            n_done    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                mem_rd_en = 1'b1;
                n_state   = S_LEG;
            end
            S_LEG: begin
                if (ent.action) begin
                    n_pump    = ent.start;
                    n_changed = 1'b1;
                    n_strobe  = 1'b1;
                    n_state   = S_ADV;
                end else if (!r_started) begin
                    n_state = S_END;
                end else begin
                    n_changed = 1'b0;
                    n_state   = S_REM;
                end
            end
            // end time = now + timeout, saturating
            S_END: begin
                alu_a     = r_now;
                alu_b     = {32'b0, ent.timeout};
                n_end     = alu_carry ? {64{1'b1}} : alu_sum;
                n_started = 1'b1;
                n_changed = 1'b1;
                n_state   = S_REM;
            end
            // remaining time = end - now
            S_REM: begin
                alu_a   = r_end;
                alu_b   = r_now;
                alu_sub = 1'b1;
                n_rem   = alu_sum;
                n_le    = !(alu_carry && (alu_sum != 64'd0));
                if (ent.delta == 9'sd0) begin
                    n_pump  = ent.start;
                    n_state = S_ADV;
                end else begin
                    n_changed = 1'b1;
                    if (!(alu_carry && (alu_sum != 64'd0))) begin
                        n_pump  = ent.start + d_u[7:0];
                        n_state = S_ADV;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            // remaining below timeout, else no elapsed time
            S_CMP: begin
                alu_a   = r_rem;
                alu_b   = {32'b0, ent.timeout};
                alu_sub = 1'b1;
                if (alu_carry) begin
                    n_pump  = ent.start;
                    n_state = S_ADV;
                end else begin
                    n_state = S_EL;
                end
            end
            // elapsed = timeout - remaining
            S_EL: begin
                alu_a   = {32'b0, ent.timeout};
                alu_b   = r_rem;
                alu_sub = 1'b1;
                n_el    = alu_sum[31:0];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_mag   = {32'b0, d_abs} * {9'b0, r_el};
                n_dvs   = {ent.timeout, 8'b0};
                n_q     = 9'd0;
                n_k     = 4'd8;
                n_state = S_DIV;
            end
            // restoring divide, one quotient bit a step, quotient below 512
            S_DIV: begin
                alu_a   = {23'b0, r_mag};
                alu_b   = {24'b0, r_dvs};
                alu_sub = 1'b1;
                if (alu_carry) begin
                    n_mag         = alu_sum[40:0];
                    n_q[r_k[3:0]] = 1'b1;
                end
                n_dvs = r_dvs >> 1;
                if (r_k == 4'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_k = r_k - 4'd1;
                end
            end
            // floor for rising ramps, ceiling of magnitude for falling ones
            S_FIN: begin
                n_pump  = d_u[8] ? (ent.start - qc[7:0]) : (ent.start + qc[7:0]);
                n_state = S_ADV;
            end
            S_ADV: begin
                if (ended) begin
                    n_cur     = r_cur + 4'd1;
                    n_started = 1'b0;
                    if (({1'b0, r_cur} + 5'd1) >= {1'b0, cnt}) begin
                        n_done = 1'b1;
                        n_pump = 8'd0;
                    end
                end
                n_out_pend = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= 4'd0;
            r_started  <= 1'b0;
            r_end      <= 64'd0;
            r_pump     <= 8'd0;
            r_changed  <= 1'b0;
            r_done     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_out_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_started  <= n_started;
            r_end      <= n_end;
            r_pump     <= n_pump;
            r_changed  <= n_changed;
            r_done     <= n_done;
            r_ovalid   <= n_ovalid;
            r_out_pend <= n_out_pend;
        end
    end

    // working data
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_trig   <= n_trig;
        r_strobe <= n_strobe;
        r_status <= n_status;
        r_rem    <= n_rem;
        r_le     <= n_le;
        r_el     <= n_el;
        r_mag    <= n_mag;
        r_dvs    <= n_dvs;
        r_q      <= n_q;
        r_k      <= n_k;
        r_out    <= n_out;
    end

endmodule

// File: test/tb_pump_ramp_leg_sequencer_unit.sv
// self-checking testbench for the pump ramp leg sequencer top level
// depends on prl_pkg and pump_ramp_leg_sequencer_unit; predicts every result beat in line
module tb_pump_ramp_leg_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import prl_pkg::*;

    localparam logic [2:0] LEG_COUNT_ADDR = 3'd0;
    localparam int STALL_LIMIT = 3000;
    localparam int TARGET_ITEMS = 1300;
    localparam int SETTLE_CYCLES = 40;

    // one request beat, field by field
    typedef struct {
        t_req        req;
        logic [63:0] now;
        logic        trig;
        logic [7:0]  idx;
        logic [7:0]  sp;
        logic [7:0]  ep;
        logic [31:0] to;
        logic        act;
        logic        utrig;
    } pump_cmd_t;

    // one result beat, field by field
    typedef struct {
        logic [7:0] pump;
        logic       changed;
        logic       finished;
        logic       strobe;
        logic [3:0] leg;
        logic       status;
    } pump_res_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // now_us, trigger_hit, leg_index, leg_start_power, leg_end_power,
    // leg_timeout_us, leg_is_action, leg_uses_trigger, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pump_setting, pump_changed, routine_finished, action_strobe, active_leg, status
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    pump_ramp_leg_sequencer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    pump_cmd_t pump_requests[$];
    pump_res_t pump_results_due[$];
    pump_cmd_t beat_in_flight;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        error_count = 0;
    int        items_queued = 0;
    int        quiet_cycles = 0;

    // shadow of the sequencer state
    logic [7:0]        prof_start[MAX_LEGS_DEF];
    logic signed [8:0] prof_delta[MAX_LEGS_DEF];
    logic [31:0]       prof_tout[MAX_LEGS_DEF];
    logic              prof_act[MAX_LEGS_DEF];
    logic              prof_trg[MAX_LEGS_DEF];
    int                prof_leg = 0;
    logic              prof_started = 1'b0;
    logic [63:0]       prof_end = '0;
    logic [7:0]        prof_pump = '0;
    logic              prof_changed = 1'b0;
    logic              prof_done = 1'b0;
    logic [3:0]        prof_count_reg = 4'd1;

    initial begin
        for (int i = 0; i < MAX_LEGS_DEF; i++) begin
            prof_start[i] = '0;
            prof_delta[i] = '0;
            prof_tout[i]  = '0;
            prof_act[i]   = 1'b0;
            prof_trg[i]   = 1'b0;
        end
    end

    function automatic int legs_in_use();
        return (prof_count_reg < MAX_LEGS_DEF) ? int'(prof_count_reg) : MAX_LEGS_DEF;
    endfunction

    // one tick of leg i; returns 1 when the leg has ended
    function automatic logic ramp_leg_tick(int i, logic [63:0] now, logic trig,
                                           output logic strobe);
        logic [64:0]       sum;
        longint unsigned   t64, rem, el, mag, absd;
        longint            q, tmp;
        int                d;
        strobe = 1'b0;
        if (prof_act[i]) begin
            strobe = 1'b1;
            prof_pump = prof_start[i];
            prof_changed = 1'b1;
            return 1'b1;
        end
        t64 = prof_tout[i];
        if (!prof_started) begin
            sum = {1'b0, now} + {33'b0, prof_tout[i]};
            prof_end = sum[64] ? '1 : sum[63:0];
            prof_started = 1'b1;
            prof_changed = 1'b1;
        end else begin
            prof_changed = 1'b0;
        end
        d = int'(prof_delta[i]);
        if (d != 0) begin
            q = 0;
            prof_changed = 1'b1;
            if (prof_end > now) begin
                rem = prof_end - now;
                if (rem < t64) begin
                    el = t64 - rem;
                    absd = (d < 0) ? -d : d;
                    mag = absd * el;
                    if (d < 0) begin
                        q = (mag + t64 - 1) / t64;
                        q = -q;
                    end else begin
                        q = mag / t64;
                    end
                end
            end else begin
                q = d;
            end
            tmp = q + longint'(prof_start[i]);
            prof_pump = tmp[7:0];
        end else begin
            prof_pump = prof_start[i];
        end
        return (prof_end <= now) || (prof_trg[i] && trig);
    endfunction

    // expected result of one accepted request, updating the shadow state
    function automatic pump_res_t step_pump_profile(pump_cmd_t c);
        pump_res_t r;
        logic      strobe;
        logic      status;
        strobe = 1'b0;
        status = 1'b0;
        case (c.req)
            REQ_TICK: begin
                if (prof_done) begin
                    prof_pump = '0;
                end else if (prof_leg >= legs_in_use()) begin
                    prof_done = 1'b1;
                    prof_pump = '0;
                end else if (ramp_leg_tick(prof_leg, c.now, c.trig, strobe)) begin
                    prof_leg++;
                    prof_started = 1'b0;
                    if (prof_leg >= legs_in_use()) begin
                        prof_done = 1'b1;
                        prof_pump = '0;
                    end
                end
            end
            REQ_WRITE: begin
                if (int'(c.idx) >= legs_in_use()) begin
                    status = 1'b1;
                end else begin
                    prof_start[c.idx] = c.sp;
                    prof_act[c.idx] = c.act;
                    if (c.act) begin
                        prof_delta[c.idx] = '0;
                        prof_tout[c.idx]  = '0;
                        prof_trg[c.idx]   = 1'b0;
                    end else begin
                        prof_delta[c.idx] = {1'b0, c.ep} - {1'b0, c.sp};
                        prof_tout[c.idx]  = c.to;
                        prof_trg[c.idx]   = c.utrig;
                    end
                    if (int'(c.idx) == prof_leg) prof_started = 1'b0;
                end
            end
            REQ_RESTART: begin
                prof_leg = 0;
                prof_started = 1'b0;
                prof_pump = '0;
                prof_changed = 1'b0;
                prof_done = 1'b0;
            end
            default: ;
        endcase
        r.pump     = prof_pump;
        r.changed  = prof_changed;
        r.finished = prof_done;
        r.strobe   = strobe;
        r.leg      = prof_leg[3:0];
        r.status   = status;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cmd(pump_cmd_t c);
        return {5'b0, c.utrig, c.act, c.to, c.ep, c.sp, c.idx, c.trig, c.now};
    endfunction

    // driver: feeds request beats from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pump_results_due.push_back(step_pump_profile(beat_in_flight));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pump_requests.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    beat_in_flight = pump_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_cmd(beat_in_flight);
                    s_axis_tuser  <= beat_in_flight.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // monitor: checks each result beat against the oldest expectation
    always @(posedge i_clk) begin
        pump_res_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pump_results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %0h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = pump_results_due.pop_front();
                    check_field("pump_setting", want.pump, m_axis_tdata[7:0]);
                    check_field("pump_changed", want.changed, m_axis_tdata[8]);
                    check_field("routine_finished", want.finished, m_axis_tdata[9]);
                    check_field("action_strobe", want.strobe, m_axis_tdata[10]);
                    check_field("active_leg", want.leg, m_axis_tdata[14:11]);
                    check_field("status", want.status, m_axis_tdata[15]);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog on cycles without any accepted beat or register access
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
            !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("pump_ramp_leg_sequencer_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // wait until no request is pending and no result is outstanding
    task automatic drain();
        @(negedge i_clk);
        while (pump_requests.size() != 0 || s_axis_tvalid || pump_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // leg count register write plus read-back, only while idle
    task automatic set_leg_count(logic [3:0] value);
        drain();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEG_COUNT_ADDR;
        pwdata  <= {$urandom_range(0, 1) ? 28'h0 : 28'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        prof_count_reg = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != {28'h0, value}) begin
            $display("%0t: leg count read mismatch, expected %0h actual %0h",
                     $time, {28'h0, value}, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic pump_cmd_t random_cmd(t_req kind);
        pump_cmd_t c;
        c.req   = kind;
        c.now   = {$urandom, $urandom};
        c.trig  = $urandom_range(0, 1);
        c.idx   = $urandom_range(0, 255);
        c.sp    = $urandom_range(0, 255);
        c.ep    = $urandom_range(0, 255);
        c.to    = $urandom;
        c.act   = $urandom_range(0, 1);
        c.utrig = $urandom_range(0, 1);
        return c;
    endfunction

    function automatic logic [7:0] pick_power();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_cmd(pump_cmd_t c);
        pump_requests.push_back(c);
        items_queued++;
    endtask

    task automatic queue_tick(logic [63:0] now, logic trig);
        pump_cmd_t c;
        c = random_cmd(REQ_TICK);
        c.now  = now;
        c.trig = trig;
        queue_cmd(c);
    endtask

    task automatic queue_leg(int idx, logic [7:0] sp, logic [7:0] ep, logic [31:0] to,
                             logic act, logic utrig);
        pump_cmd_t c;
        c = random_cmd(REQ_WRITE);
        c.idx = idx;
        c.sp = sp;
        c.ep = ep;
        c.to = to;
        c.act = act;
        c.utrig = utrig;
        queue_cmd(c);
    endtask

    // one routine: load legs, restart, then ticks with noise mixed in
    task automatic run_routine(logic [63:0] start_now);
        logic [3:0]  n;
        int          eff, ticks, sel;
        int unsigned span;
        logic [63:0] now;
        pump_cmd_t   c;
        sel = $urandom_range(0, 9);
        n = (sel == 0) ? 4'd0 : (sel == 1) ? 4'($urandom_range(9, 15)) :
            4'($urandom_range(1, 8));
        if (n != prof_count_reg) set_leg_count(n);
        eff = (n < MAX_LEGS_DEF) ? int'(n) : MAX_LEGS_DEF;
        sel = $urandom_range(0, 2);
        span = (sel == 0) ? 10 : (sel == 1) ? 1000 : 100000;
        now = start_now;
        for (int i = 0; i < eff; i++) begin
            c = random_cmd(REQ_WRITE);
            c.idx = i;
            c.sp = pick_power();
            c.ep = pick_power();
            c.act = ($urandom_range(0, 3) == 0);
            c.to = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, span);
            queue_cmd(c);
            if ($urandom_range(0, 7) == 0) begin
                c = random_cmd(REQ_WRITE);
                c.idx = $urandom_range(eff, 255);
                queue_cmd(c);
            end
        end
        queue_cmd(random_cmd(REQ_RESTART));
        ticks = eff * 4 + 4;
        for (int k = 0; k < ticks; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) now = now - $urandom_range(0, span);
            else if (sel < 7) now = {$urandom, $urandom};
            else if (sel < 9) now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, span);
            else now = now + $urandom_range(0, span / 2 + 1);
            queue_tick(now, $urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                queue_cmd(random_cmd(REQ_NONE));
            end else if (sel < 8) begin
                c = random_cmd(REQ_WRITE);
                c.idx = $urandom_range(0, eff);
                c.to = $urandom_range(0, span);
                queue_cmd(c);
            end else if (sel < 9) begin
                queue_cmd(random_cmd(REQ_RESTART));
            end
            // the leg count may drop below the running leg
            if (k == ticks / 2 && $urandom_range(0, 7) == 0)
                set_leg_count(4'($urandom_range(0, eff)));
        end
    endtask

    // reset, directed cases, then three idling phases of random routines
    initial begin
        pump_cmd_t c;
        logic [63:0] base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 17;
        recv_idle = 46;

        // default table with one leg: zero timeout ends at once
        queue_tick(64'd0, 1'b0);
        queue_tick(64'd5, 1'b0);
        queue_cmd(random_cmd(REQ_NONE));
        queue_leg(1, 8'd9, 8'd9, 32'd9, 1'b0, 1'b0);
        queue_leg(255, 8'd9, 8'd9, 32'd9, 1'b0, 1'b0);
        queue_leg(0, 8'd0, 8'd255, 32'd100, 1'b0, 1'b1);
        queue_cmd(random_cmd(REQ_RESTART));
        queue_tick(64'd1000, 1'b0);
        queue_tick(64'd1050, 1'b0);
        queue_tick(64'd1060, 1'b1);

        // eight legs: action, saturating end time, flat leg, zero timeout, backwards time
        set_leg_count(4'd8);
        queue_leg(0, 8'd255, 8'd3, 32'd77, 1'b1, 1'b1);
        queue_leg(1, 8'd255, 8'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_leg(2, 8'd77, 8'd77, 32'd10, 1'b0, 1'b0);
        queue_leg(3, 8'd10, 8'd20, 32'd0, 1'b0, 1'b0);
        queue_leg(4, 8'd0, 8'd200, 32'd1000, 1'b0, 1'b0);
        queue_cmd(random_cmd(REQ_RESTART));
        queue_tick(64'd5, 1'b1);
        queue_tick(64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
        queue_tick(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_tick(64'd100, 1'b0);
        queue_tick(64'd105, 1'b0);
        queue_leg(2, 8'd77, 8'd77, 32'd10, 1'b0, 1'b0);
        queue_tick(64'd120, 1'b0);
        queue_tick(64'd130, 1'b0);
        queue_tick(64'd140, 1'b0);
        queue_tick(64'd200, 1'b0);
        queue_tick(64'd100, 1'b0);
        queue_tick(64'd700, 1'b0);
        set_leg_count(4'd2);
        queue_tick(64'd800, 1'b0);
        set_leg_count(4'd15);
        queue_tick(64'd900, 1'b0);

        // random routines, idling pattern switched by phase
        base = 64'd0;
        while (items_queued < TARGET_ITEMS) begin
            if (items_queued >= TARGET_ITEMS / 3 && send_idle == 17) begin
                drain();
                send_idle = 46;
                recv_idle = 17;
            end else if (items_queued >= 2 * TARGET_ITEMS / 3 && send_idle == 46) begin
                drain();
                send_idle = 0;
                recv_idle = 0;
            end
            base = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
                   base + $urandom_range(0, 50000);
            run_routine(base);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("pump_ramp_leg_sequencer_unit verification clean");
        end else begin
            $display("pump_ramp_leg_sequencer_unit verification failed");
        end
        $finish;
    end

endmodule
